FILE: sv/mnf_pkg.sv
// Shared types and constants for the normal-form word multiplier.
package mnf_pkg;

	localparam int LW         = 6;
	localparam int LETTER_MAX = 63;
	localparam int RESULT_CAP = 32;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_MUL    = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_UNSORTED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	// Control broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic          cmp_en;
		logic          mul;
		logic          ins_en;
		logic          rot_en;
		logic [LW-1:0] cmp_letter;
		logic [LW-1:0] ins_letter;
	} cell_ctrl_t;

endpackage

FILE: sv/mnf_cell.sv
// One letter slot of the word row with its compare flags and neighbor moves.
module mnf_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  logic                    clk,
	input  mnf_pkg::cell_ctrl_t     ctrl,
	input  logic [CW-1:0]           length,
	input  logic [mnf_pkg::LW-1:0]  left_letter,
	input  logic [mnf_pkg::LW-1:0]  right_letter,
	input  logic [mnf_pkg::LW-1:0]  first_letter,
	input  logic                    seen_in,
	output logic [mnf_pkg::LW-1:0]  letter,
	output logic                    seen_out,
	output logic                    at_ins,
	output logic                    lt_flag
);

	localparam int LW = mnf_pkg::LW;

	logic [LW-1:0] letter_q;
	logic          ins_s1;
	logic          lt_s1;
	logic          beyond;
	logic          ge;
	logic          is_last;

	assign beyond  = CW'(IDX) >= length;
	// The scanned letter has grown by one for each cell passed on the left.
	assign ge      = {1'b0, letter_q} >= ((LW+1)'(ctrl.cmp_letter) + (LW+1)'(IDX));
	assign is_last = (length != '0) && (CW'(IDX) == length - CW'(1));

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			ins_s1 <= beyond | (ctrl.mul & ge);
			lt_s1  <= !beyond & (ctrl.cmp_letter < letter_q);
		end
	end

	assign seen_out = seen_in | ins_s1;
	assign at_ins   = ins_s1 & !seen_in;
	assign lt_flag  = lt_s1;
	assign letter   = letter_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (at_ins) begin
				letter_q <= ctrl.ins_letter;
			end else if (seen_in) begin
				letter_q <= left_letter;
			end
		end else if (ctrl.rot_en && !beyond) begin
			letter_q <= is_last ? first_letter : right_letter;
		end
	end

endmodule

FILE: sv/monoid_normal_form_left_multiply.sv
// Top level: sequencer, length register and output register around the cell row.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------------------
//   item     | item_valid / item_stall  | mode, letter
//   result   | res_valid / res_stall    | out_letter, position, length, status,
//            |                          | empty_res, last
//
// Clear, append and left-multiply run as an accept step, where every cell compares its
// letter, and an execute step, where the insertion point ripples along the row and the
// cells shift right behind it.
// A readout rotates the row by one cell a cycle unless a stalled result holds it.
// Reset clears the word length; the stored letters stay undefined until written.
// A stalled result holds the block in its execute or readout step.
module monoid_normal_form_left_multiply #(
	parameter int MAX_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] mode,
	input  logic [5:0] letter,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [5:0] out_letter,
	output logic [5:0] position,
	output logic [5:0] length,
	output logic [1:0] status,
	output logic       empty_res,
	output logic       last
);

	localparam int LW   = mnf_pkg::LW;
	localparam int CW   = $clog2(MAX_LEN + 1);
	localparam int JW   = ((CW > LW) ? CW : LW) + 1;

	mnf_pkg::state_t   state_q, state_d;
	mnf_pkg::mode_t    mode_q;
	logic [LW-1:0]     letter_q;
	logic [CW-1:0]     len_q, len_d;
	logic [CW-1:0]     rd_q, rd_d;

	logic              out_valid_q;
	logic [LW-1:0]     out_letter_q;
	logic [LW-1:0]     position_q;
	logic [LW-1:0]     length_q;
	mnf_pkg::status_t  status_q;
	logic              empty_q;
	logic              last_q;

	logic              out_load;
	logic [LW-1:0]     ld_letter;
	logic [LW-1:0]     ld_position;
	logic [LW-1:0]     ld_length;
	mnf_pkg::status_t  ld_status;
	logic              ld_empty;
	logic              ld_last;

	logic              accept;
	logic              out_free;
	mnf_pkg::cell_ctrl_t ctrl;

	logic [LW-1:0]     cell_letter [MAX_LEN];
	logic              seen [MAX_LEN+1];
	logic [MAX_LEN-1:0] at_vec;
	logic [MAX_LEN-1:0] lt_vec;

	logic [CW-1:0]     k_or;
	logic [CW-1:0]     ins_pos;
	logic [JW-1:0]     j_val;
	logic              full;
	logic              unsorted;
	logic [JW-1:0]     rd_cnt;
	logic              rd_emit;

	assign accept     = item_valid && !item_stall;
	assign item_stall = state_q != mnf_pkg::ST_IDLE;
	assign out_free   = !out_valid_q || !res_stall;

	// ---------------- cell row ----------------
	assign seen[0] = 1'b0;

	for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
		logic [LW-1:0] left_l;
		logic [LW-1:0] right_l;

		if (gi == 0) begin : g_first
			assign left_l = '0;
		end else begin : g_mid_l
			assign left_l = cell_letter[gi-1];
		end
		if (gi == MAX_LEN - 1) begin : g_end
			assign right_l = '0;
		end else begin : g_mid_r
			assign right_l = cell_letter[gi+1];
		end

		mnf_cell #(
			.IDX (gi),
			.CW  (CW)
		) u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.length       (len_q),
			.left_letter  (left_l),
			.right_letter (right_l),
			.first_letter (cell_letter[0]),
			.seen_in      (seen[gi]),
			.letter       (cell_letter[gi]),
			.seen_out     (seen[gi+1]),
			.at_ins       (at_vec[gi]),
			.lt_flag      (lt_vec[gi])
		);
	end

	always_comb begin
		k_or = '0;
		for (int i = 0; i < MAX_LEN; i++) begin
			if (at_vec[i]) begin
				k_or = k_or | CW'(i);
			end
		end
	end

	// No cell reports a stop only when the word is full and every letter was passed.
	assign ins_pos  = seen[MAX_LEN] ? k_or : len_q;
	assign j_val    = JW'(letter_q) + JW'(ins_pos);
	assign full     = len_q == CW'(MAX_LEN);
	// The word is sorted, so a letter below any stored one is below the last one.
	assign unsorted = |lt_vec;
	assign rd_cnt   = (JW'(len_q) < JW'(mnf_pkg::RESULT_CAP)) ?
	                  JW'(len_q) : JW'(mnf_pkg::RESULT_CAP);
	assign rd_emit  = JW'(rd_q) < rd_cnt;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d          = state_q;
		len_d            = len_q;
		rd_d             = rd_q;
		ctrl.cmp_en      = accept;
		ctrl.mul         = mode == mnf_pkg::MODE_MUL;
		ctrl.cmp_letter  = letter;
		ctrl.ins_en      = 1'b0;
		ctrl.rot_en      = 1'b0;
		ctrl.ins_letter  = letter_q;
		out_load         = 1'b0;
		ld_letter        = '0;
		ld_position      = '0;
		ld_length        = LW'(len_q);
		ld_status        = mnf_pkg::STAT_OK;
		ld_empty         = 1'b0;
		ld_last          = 1'b1;

		case (state_q)
			mnf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = mnf_pkg::ST_EXEC;
				end
			end
			mnf_pkg::ST_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = mnf_pkg::ST_IDLE;
					case (mode_q)
						mnf_pkg::MODE_CLEAR: begin
							len_d     = '0;
							ld_length = '0;
						end
						mnf_pkg::MODE_APPEND: begin
							if (full) begin
								ld_status = mnf_pkg::STAT_FULL;
							end else if (unsorted) begin
								ld_status = mnf_pkg::STAT_UNSORTED;
							end else begin
								ctrl.ins_en = 1'b1;
								len_d       = len_q + CW'(1);
								ld_letter   = letter_q;
								ld_position = LW'(len_q);
								ld_length   = LW'(len_d);
							end
						end
						mnf_pkg::MODE_MUL: begin
							if (j_val > JW'(mnf_pkg::LETTER_MAX)) begin
								ld_status = mnf_pkg::STAT_OVERFLOW;
							end else if (full) begin
								ld_status = mnf_pkg::STAT_FULL;
							end else begin
								ctrl.ins_en     = 1'b1;
								ctrl.ins_letter = LW'(j_val);
								len_d           = len_q + CW'(1);
								ld_letter       = LW'(j_val);
								ld_position     = LW'(ins_pos);
								ld_length       = LW'(len_d);
							end
						end
						mnf_pkg::MODE_READ: begin
							if (len_q == '0) begin
								ld_empty = 1'b1;
							end else begin
								out_load = 1'b0;
								rd_d     = '0;
								state_d  = mnf_pkg::ST_READ;
							end
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			mnf_pkg::ST_READ: begin
				// Cell 0 holds letter rd_q; the row rotates once per step.
				if (!rd_emit || out_free) begin
					ctrl.rot_en = 1'b1;
					out_load    = rd_emit;
					ld_letter   = cell_letter[0];
					ld_position = LW'(rd_q);
					ld_last     = (JW'(rd_q) + JW'(1)) == rd_cnt;
					rd_d        = rd_q + CW'(1);
					if (rd_q == len_q - CW'(1)) begin
						state_d = mnf_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = mnf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mnf_pkg::ST_IDLE;
			len_q       <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			rd_q    <= rd_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mnf_pkg::mode_t'(mode);
			letter_q <= letter;
		end
		if (out_load) begin
			out_letter_q <= ld_letter;
			position_q   <= ld_position;
			length_q     <= ld_length;
			status_q     <= ld_status;
			empty_q      <= ld_empty;
			last_q       <= ld_last;
		end
	end

	assign res_valid  = out_valid_q;
	assign out_letter = out_letter_q;
	assign position   = position_q;
	assign length     = length_q;
	assign status     = status_q;
	assign empty_res  = empty_q;
	assign last       = last_q;

	// ---------------- assertions ----------------
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(MAX_LEN))
		else $error("word length beyond capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == mnf_pkg::ST_EXEC)
		else $error("accepted transaction not executed next cycle");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins_en |=> len_q == $past(len_q) + CW'(1))
		else $error("insertion did not grow the word by one");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != mnf_pkg::STAT_OK) |->
		(out_letter_q == '0 && position_q == '0))
		else $error("error result carries letter or position");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |-> (last_q && length_q == '0))
		else $error("empty readout result malformed");

endmodule

FILE: bench/monoid_normal_form_left_multiply_tb.sv
// Self-checking testbench for the normal-form word multiplier: directed and random transactions.
module monoid_normal_form_left_multiply_tb;

	localparam int WORD_CAP     = 32;
	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 10;
	localparam int MAX_GAP      = 8;
	localparam int MAX_STALL    = 8;
	localparam int HANG_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 2 * WORD_CAP + 8;
	localparam int REPORT_MAX   = 10;
	localparam int EXP_DEPTH    = 64;

	typedef struct {
		logic [5:0]       out_letter;
		logic [5:0]       position;
		logic [5:0]       length;
		mnf_pkg::status_t status;
		logic             empty_res;
		logic             last;
	} word_result_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	mnf_pkg::mode_t mode = mnf_pkg::MODE_CLEAR;
	logic [5:0]     letter = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	logic [5:0]     out_letter;
	logic [5:0]     position;
	logic [5:0]     length;
	logic [1:0]     status;
	logic           empty_res;
	logic           last;

	// Shadow copy of the stored word, updated when a transaction is accepted.
	logic [5:0]   shadow_word [WORD_CAP];
	int           shadow_len = 0;
	// Circular buffer of predicted results, written at accept and read by the checker.
	word_result_t exp_buf [EXP_DEPTH];
	int           exp_wr = 0;
	int           exp_rd = 0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int stall_run = 0;
	int fail_count = 0;
	int hang_cycles = 0;

	monoid_normal_form_left_multiply #(.MAX_LEN(WORD_CAP)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.letter     (letter),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_letter (out_letter),
		.position   (position),
		.length     (length),
		.status     (status),
		.empty_res  (empty_res),
		.last       (last)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic word_result_t make_result(logic [5:0] l, logic [5:0] p,
			logic [5:0] n, mnf_pkg::status_t s, logic e, logic f);
		word_result_t r;
		r.out_letter = l;
		r.position   = p;
		r.length     = n;
		r.status     = s;
		r.empty_res  = e;
		r.last       = f;
		return r;
	endfunction

	function automatic void store_expected(input word_result_t r);
		exp_buf[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endfunction

	task automatic predict_word_op(input mnf_pkg::mode_t m, input logic [5:0] l);
		int n;
		int j;
		int k;
		int cnt;
		n = shadow_len;
		case (m)
			mnf_pkg::MODE_CLEAR: begin
				shadow_len = 0;
				store_expected(make_result('0, '0, '0, mnf_pkg::STAT_OK, 1'b0, 1'b1));
			end
			mnf_pkg::MODE_APPEND: begin
				if (n >= WORD_CAP) begin
					store_expected(make_result('0, '0, 6'(n), mnf_pkg::STAT_FULL,
						1'b0, 1'b1));
				end else if (n > 0 && l < shadow_word[n-1]) begin
					store_expected(make_result('0, '0, 6'(n), mnf_pkg::STAT_UNSORTED,
						1'b0, 1'b1));
				end else begin
					shadow_word[n] = l;
					shadow_len = n + 1;
					store_expected(make_result(l, 6'(n), 6'(n + 1), mnf_pkg::STAT_OK,
						1'b0, 1'b1));
				end
			end
			mnf_pkg::MODE_MUL: begin
				// The multiplier letter climbs by one past every smaller stored letter.
				j = l;
				k = 0;
				while (k < n && shadow_word[k] < j) begin
					j++;
					k++;
				end
				if (j > mnf_pkg::LETTER_MAX) begin
					store_expected(make_result('0, '0, 6'(n), mnf_pkg::STAT_OVERFLOW,
						1'b0, 1'b1));
				end else if (n >= WORD_CAP) begin
					store_expected(make_result('0, '0, 6'(n), mnf_pkg::STAT_FULL,
						1'b0, 1'b1));
				end else begin
					for (int i = n; i > k; i--)
						shadow_word[i] = shadow_word[i-1];
					shadow_word[k] = 6'(j);
					shadow_len = n + 1;
					store_expected(make_result(6'(j), 6'(k), 6'(n + 1), mnf_pkg::STAT_OK,
						1'b0, 1'b1));
				end
			end
			default: begin
				if (n == 0) begin
					store_expected(make_result('0, '0, '0, mnf_pkg::STAT_OK, 1'b1, 1'b1));
				end else begin
					cnt = (n < mnf_pkg::RESULT_CAP) ? n : mnf_pkg::RESULT_CAP;
					for (int i = 0; i < cnt; i++)
						store_expected(make_result(shadow_word[i], 6'(i), 6'(n),
							mnf_pkg::STAT_OK, 1'b0, i == cnt - 1));
				end
			end
		endcase
	endtask

	// Called at a rising edge; returns at the edge where the transaction is accepted.
	task automatic send_item(input mnf_pkg::mode_t m, input logic [5:0] l);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			gap++;
		end
		item_valid <= 1'b1;
		mode       <= m;
		letter     <= l;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_word_op(m, l);
	endtask

	always @(posedge clk) begin
		if (stall_run >= MAX_STALL || $urandom_range(0, 99) >= stall_pct) begin
			res_stall <= 1'b0;
			stall_run <= 0;
		end else begin
			res_stall <= 1'b1;
			stall_run <= stall_run + 1;
		end
	end

	always @(posedge clk) begin : check_results
		word_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (exp_wr == exp_rd) begin
				if (fail_count < REPORT_MAX)
					$display({"unexpected result: letter=%0d pos=%0d len=%0d",
						" status=%0d empty=%0d last=%0d"},
						out_letter, position, length, status, empty_res, last);
				fail_count++;
			end else begin
				want = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (out_letter !== want.out_letter || position !== want.position ||
						length !== want.length || status !== want.status ||
						empty_res !== want.empty_res || last !== want.last) begin
					if (fail_count < REPORT_MAX) begin
						$display({"mismatch: expected letter=%0d pos=%0d len=%0d",
							" status=%0d empty=%0d last=%0d"},
							want.out_letter, want.position, want.length, want.status,
							want.empty_res, want.last);
						$display({"          actual   letter=%0d pos=%0d len=%0d",
							" status=%0d empty=%0d last=%0d"},
							out_letter, position, length, status, empty_res, last);
					end
					fail_count++;
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
			hang_cycles <= 0;
		end else if (hang_cycles >= HANG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			hang_cycles <= hang_cycles + 1;
		end
	end

	task automatic test_basic_ops;
		send_item(mnf_pkg::MODE_CLEAR, 6'd63);
		send_item(mnf_pkg::MODE_READ, 6'd42);
		send_item(mnf_pkg::MODE_MUL, 6'd63);
		send_item(mnf_pkg::MODE_APPEND, 6'd10);
		send_item(mnf_pkg::MODE_APPEND, 6'd63);
		send_item(mnf_pkg::MODE_READ, 6'd21);
		send_item(mnf_pkg::MODE_CLEAR, 6'd21);
		send_item(mnf_pkg::MODE_APPEND, 6'd0);
		send_item(mnf_pkg::MODE_APPEND, 6'd0);
		send_item(mnf_pkg::MODE_APPEND, 6'd5);
		send_item(mnf_pkg::MODE_APPEND, 6'd4);
		send_item(mnf_pkg::MODE_MUL, 6'd0);
		send_item(mnf_pkg::MODE_MUL, 6'd1);
		send_item(mnf_pkg::MODE_MUL, 6'd62);
		send_item(mnf_pkg::MODE_MUL, 6'd60);
		// Climbs to exactly the top letter without overflowing.
		send_item(mnf_pkg::MODE_MUL, 6'd58);
		send_item(mnf_pkg::MODE_READ, 6'd0);
		send_item(mnf_pkg::MODE_CLEAR, 6'd42);
	endtask

	task automatic test_full_word;
		send_item(mnf_pkg::MODE_CLEAR, 6'd0);
		for (int i = 0; i < WORD_CAP; i++)
			send_item(mnf_pkg::MODE_APPEND, 6'(2 * i));
		send_item(mnf_pkg::MODE_APPEND, 6'd62);
		send_item(mnf_pkg::MODE_MUL, 6'd0);
		// Overflow takes precedence over the full word.
		send_item(mnf_pkg::MODE_MUL, 6'd63);
		send_item(mnf_pkg::MODE_MUL, 6'd31);
		send_item(mnf_pkg::MODE_READ, 6'd63);
		send_item(mnf_pkg::MODE_CLEAR, 6'd0);
	endtask

	task automatic test_random(input int n_items, input int idle_pct, input int stall_in);
		mnf_pkg::mode_t m;
		logic [5:0]     l;
		int             pick;
		int             step_top;
		send_idle_pct = idle_pct;
		stall_pct     = stall_in;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			l    = 6'($urandom_range(0, 63));
			if (pick < 4 || (shadow_len >= WORD_CAP && pick < 30)) begin
				m = mnf_pkg::MODE_CLEAR;
			end else if (pick < 12) begin
				m = mnf_pkg::MODE_READ;
			end else if (pick < 50) begin
				// Mostly sorted appends in small steps so that long words build up.
				m = mnf_pkg::MODE_APPEND;
				if (shadow_len > 0 && pick >= 16) begin
					step_top = shadow_word[shadow_len-1] + 3;
					if (step_top > mnf_pkg::LETTER_MAX)
						step_top = mnf_pkg::LETTER_MAX;
					l = 6'($urandom_range(shadow_word[shadow_len-1], step_top));
				end
			end else if (pick < 92) begin
				m = mnf_pkg::MODE_MUL;
				if (pick < 86)
					l = 6'($urandom_range(0, mnf_pkg::LETTER_MAX - shadow_len));
			end else begin
				m = mnf_pkg::mode_t'($urandom_range(0, 3));
			end
			send_item(m, l);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops;
		test_full_word;
		test_random(40, 0, 0);
		test_random(40, 46, 0);
		test_random(40, 0, 46);
		test_random(40, 14, 14);
		item_valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
